// ===== rtl/lavm_pkg.sv =====
// Shared types, constants and a helper function of the look-at view matrix core.
package lavm_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int BASIS_W = 32;
	localparam int BASIS_FRAC = 30;
	localparam int NORM_LAT = 69;

	typedef logic [2:0][31:0] vec32_t;
	typedef logic [2:0][63:0] vec64_t;

	typedef struct packed {
		logic [2:0][29:0] m;
		logic [2:0]       neg;
		logic             zero;
	} lavm_side_t;

	function automatic logic [6:0] blen(input logic [63:0] x);
		logic [6:0] n;
		n = '0;
		for (int i = 0; i < 64; i++) begin
			if (x[i]) begin
				n = 7'(i + 1);
			end
		end
		return n;
	endfunction

endpackage

// ===== rtl/lavm_norm.sv =====
// Pipelined vector normalizer: power-of-two prescale, square root and division.
module lavm_norm (
	input  logic             clk,
	input  logic             en,
	input  lavm_pkg::vec64_t a,
	output lavm_pkg::vec32_t o,
	output logic             zero
);
	import lavm_pkg::*;

	logic [2:0][63:0] mag_c;
	logic [2:0][63:0] m_s1;
	logic [2:0]       neg_s1;
	logic [63:0]      or_s1;
	logic [6:0]       len_s2;
	logic [2:0][63:0] m_s2;
	logic [2:0]       neg_s2;
	logic [2:0][63:0] sh_c;
	lavm_side_t       side_s3;
	logic [2:0][59:0] sqr_s4;
	lavm_side_t       side_s4;

	logic [61:0]      sq_x [0:31];
	logic [32:0]      sq_rem [0:31];
	logic [30:0]      sq_root [0:31];
	lavm_side_t       sq_side [0:31];

	logic [2:0][60:0] n_c;
	logic [2:0][30:0] dv_rem [0:31];
	logic [2:0][60:0] dv_n [0:31];
	logic [2:0][30:0] dv_q [0:31];
	logic [30:0]      dv_s [0:31];
	lavm_side_t       dv_side [0:31];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = a[i][63] ? 64'(-a[i]) : a[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1 <= mag_c;
			neg_s1 <= {a[2][63], a[1][63], a[0][63]};
			or_s1 <= mag_c[0] | mag_c[1] | mag_c[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_s2 <= blen(or_s1);
			m_s2 <= m_s1;
			neg_s2 <= neg_s1;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (len_s2 > 7'd30) begin
				sh_c[i] = m_s2[i] >> (len_s2 - 7'd30);
			end else begin
				sh_c[i] = m_s2[i] << (7'd30 - len_s2);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				side_s3.m[i] <= sh_c[i][29:0];
			end
			side_s3.neg <= neg_s2;
			side_s3.zero <= (len_s2 == 7'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sqr_s4[i] <= side_s3.m[i] * side_s3.m[i];
			end
			side_s4 <= side_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_x[0] <= 62'(sqr_s4[0]) + 62'(sqr_s4[1]) + 62'(sqr_s4[2]);
			sq_rem[0] <= '0;
			sq_root[0] <= '0;
			sq_side[0] <= side_s4;
		end
	end

	for (genvar j = 0; j < 31; j++) begin : g_sqrt
		localparam int K = 30 - j;
		logic [34:0] remt;
		logic [34:0] trial;
		assign remt = {sq_rem[j], sq_x[j][2*K+1:2*K]};
		assign trial = {2'b00, sq_root[j], 2'b01};
		always_ff @(posedge clk) begin
			if (en) begin
				if (remt >= trial) begin
					sq_rem[j+1] <= 33'(remt - trial);
					sq_root[j+1] <= {sq_root[j][29:0], 1'b1};
				end else begin
					sq_rem[j+1] <= remt[32:0];
					sq_root[j+1] <= {sq_root[j][29:0], 1'b0};
				end
				sq_x[j+1] <= sq_x[j];
				sq_side[j+1] <= sq_side[j];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n_c[i] = {1'b0, sq_side[31].m[i], 30'd0} + {31'd0, sq_root[31][30:1]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dv_rem[0][i] <= {1'b0, n_c[i][60:31]};
				dv_q[0][i] <= '0;
			end
			dv_n[0] <= n_c;
			dv_s[0] <= sq_root[31];
			dv_side[0] <= sq_side[31];
		end
	end

	for (genvar j = 0; j < 31; j++) begin : g_div
		localparam int K = 30 - j;
		logic [2:0][31:0] remt;
		logic [2:0]       ge;
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				remt[i] = {dv_rem[j][i], dv_n[j][i][K]};
				ge[i] = remt[i] >= {1'b0, dv_s[j]};
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (ge[i]) begin
						dv_rem[j+1][i] <= 31'(remt[i] - {1'b0, dv_s[j]});
					end else begin
						dv_rem[j+1][i] <= remt[i][30:0];
					end
					dv_q[j+1][i] <= {dv_q[j][i][29:0], ge[i]};
				end
				dv_n[j+1] <= dv_n[j];
				dv_s[j+1] <= dv_s[j];
				dv_side[j+1] <= dv_side[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				o[i] <= dv_side[31].neg[i] ? -{1'b0, dv_q[31][i]} : {1'b0, dv_q[31][i]};
			end
			zero <= dv_side[31].zero;
		end
	end

endmodule

// ===== rtl/look_at_view_matrix_core.sv =====
// Look-at view matrix core: pipelined basis and translation computation.
// One camera setup is accepted per clock cycle while in_ready is high. The two normalizers
// are each a 69-stage pipeline with one square-root bit per root stage and one quotient bit
// per division stage. A one-entry skid register holds an untaken result; while it is full,
// in_ready is low and the pipeline stalls. Inputs are signed Q16.16, the basis is signed
// Q2.30, and a zero-length direction, up vector or cross product yields an all-zero result.
module look_at_view_matrix_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   func,
	input  logic signed [lavm_pkg::DATA_WIDTH-1:0] pos_x,
	input  logic signed [lavm_pkg::DATA_WIDTH-1:0] pos_y,
	input  logic signed [lavm_pkg::DATA_WIDTH-1:0] pos_z,
	input  logic signed [lavm_pkg::DATA_WIDTH-1:0] dir_x,
	input  logic signed [lavm_pkg::DATA_WIDTH-1:0] dir_y,
	input  logic signed [lavm_pkg::DATA_WIDTH-1:0] dir_z,
	input  logic signed [lavm_pkg::DATA_WIDTH-1:0] up_x,
	input  logic signed [lavm_pkg::DATA_WIDTH-1:0] up_y,
	input  logic signed [lavm_pkg::DATA_WIDTH-1:0] up_z,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [lavm_pkg::BASIS_W-1:0]    u_x,
	output logic signed [lavm_pkg::BASIS_W-1:0]    u_y,
	output logic signed [lavm_pkg::BASIS_W-1:0]    u_z,
	output logic signed [lavm_pkg::BASIS_W-1:0]    v_x,
	output logic signed [lavm_pkg::BASIS_W-1:0]    v_y,
	output logic signed [lavm_pkg::BASIS_W-1:0]    v_z,
	output logic signed [lavm_pkg::BASIS_W-1:0]    w_x,
	output logic signed [lavm_pkg::BASIS_W-1:0]    w_y,
	output logic signed [lavm_pkg::BASIS_W-1:0]    w_z,
	output logic signed [lavm_pkg::DATA_WIDTH-1:0] trans_u,
	output logic signed [lavm_pkg::DATA_WIDTH-1:0] trans_v,
	output logic signed [lavm_pkg::DATA_WIDTH-1:0] trans_w
);
	import lavm_pkg::*;

	typedef struct packed {
		vec32_t us;
		logic   zu;
	} upl_t;

	typedef struct packed {
		vec32_t u;
		vec32_t v;
		vec32_t w;
		vec32_t t;
	} res_t;

	localparam longint TMAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
	localparam logic signed [35:0] SAT_HI = 36'(TMAX);
	localparam logic signed [35:0] SAT_LO = -36'(TMAX) - 36'sd1;

	function automatic logic signed [63:0] mul_ss(input logic signed [33:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] ax;
		logic signed [63:0] bx;
		ax = a;
		bx = b;
		return ax * bx;
	endfunction

	function automatic logic signed [33:0] rnd30(input logic signed [63:0] p);
		logic [63:0] m;
		logic [63:0] r;
		m = p[63] ? 64'(-p) : 64'(p);
		r = (m + (64'd1 << (BASIS_FRAC - 1))) >> BASIS_FRAC;
		return p[63] ? -$signed(r[33:0]) : $signed(r[33:0]);
	endfunction

	function automatic logic [DATA_WIDTH-1:0] sat(input logic signed [35:0] x);
		logic [DATA_WIDTH-1:0] r;
		if (x > SAT_HI) begin
			r = SAT_HI[DATA_WIDTH-1:0];
		end else if (x < SAT_LO) begin
			r = SAT_LO[DATA_WIDTH-1:0];
		end else begin
			r = x[DATA_WIDTH-1:0];
		end
		return r;
	endfunction

	logic en;
	logic skid_vld_q;
	res_t skid_q;
	res_t out_sel;

	logic                         vld_s1;
	logic [2:0][DATA_WIDTH:0]     d_s1;
	vec32_t                       pos_s1;
	vec32_t                       up_s1;
	vec64_t                       n1_in;
	vec32_t                       n1_o;
	logic                         n1_zero;

	vec32_t                       umag_c;
	vec32_t                       um_s2;
	logic [2:0]                   un_s2;
	logic [31:0]                  uor_s2;
	logic [6:0]                   ulen_c;
	vec32_t                       ush_c;
	vec32_t                       us_s3;
	logic                         zu_s3;

	upl_t                         up_dly_q [1:NORM_LAT-2];
	vec32_t                       pos1_dly_q [1:NORM_LAT];
	logic [NORM_LAT:1]            vld1_dly_q;

	logic signed [63:0]           cp_s71 [0:5];
	vec32_t                       w_s71;
	vec32_t                       pos_s71;
	logic                         z_s71;
	logic                         vld_s71;
	vec64_t                       c_s72;
	vec32_t                       w_s72;
	vec32_t                       pos_s72;
	logic                         z_s72;
	logic                         vld_s72;
	vec32_t                       n2_o;
	logic                         n2_zero;

	vec32_t                       w2_dly_q [1:NORM_LAT];
	vec32_t                       pos2_dly_q [1:NORM_LAT];
	logic [NORM_LAT:1]            z2_dly_q;
	logic [NORM_LAT:1]            vld2_dly_q;

	logic signed [63:0]           wu_s142 [0:5];
	vec32_t                       u_s142, w_s142, pos_s142;
	logic                         z_s142, vld_s142;
	logic signed [33:0]           wr_s143 [0:5];
	vec32_t                       u_s143, w_s143, pos_s143;
	logic                         z_s143, vld_s143;
	logic signed [33:0]           v_s144 [0:2];
	vec32_t                       u_s144, w_s144, pos_s144;
	logic                         z_s144, vld_s144;
	logic signed [63:0]           tp_s145 [0:8];
	vec32_t                       u_s145, w_s145;
	logic signed [33:0]           v_s145 [0:2];
	logic                         z_s145, vld_s145;
	logic signed [33:0]           tr_s146 [0:8];
	vec32_t                       u_s146, w_s146;
	logic signed [33:0]           v_s146 [0:2];
	logic                         z_s146, vld_s146;
	logic signed [35:0]           ts_s147 [0:2];
	vec32_t                       u_s147, w_s147;
	logic signed [33:0]           v_s147 [0:2];
	logic                         z_s147, vld_s147;
	res_t                         res_s148;
	logic                         vld_s148;

	assign en = !skid_vld_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld1_dly_q <= '0;
			vld_s71 <= 1'b0;
			vld_s72 <= 1'b0;
			vld2_dly_q <= '0;
			vld_s142 <= 1'b0;
			vld_s143 <= 1'b0;
			vld_s144 <= 1'b0;
			vld_s145 <= 1'b0;
			vld_s146 <= 1'b0;
			vld_s147 <= 1'b0;
			vld_s148 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld1_dly_q <= {vld1_dly_q[NORM_LAT-1:1], vld_s1};
			vld_s71 <= vld1_dly_q[NORM_LAT];
			vld_s72 <= vld_s71;
			vld2_dly_q <= {vld2_dly_q[NORM_LAT-1:1], vld_s72};
			vld_s142 <= vld2_dly_q[NORM_LAT];
			vld_s143 <= vld_s142;
			vld_s144 <= vld_s143;
			vld_s145 <= vld_s144;
			vld_s146 <= vld_s145;
			vld_s147 <= vld_s146;
			vld_s148 <= vld_s147;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= func ? {dir_x[DATA_WIDTH-1], dir_x} - {pos_x[DATA_WIDTH-1], pos_x}
				: {dir_x[DATA_WIDTH-1], dir_x};
			d_s1[1] <= func ? {dir_y[DATA_WIDTH-1], dir_y} - {pos_y[DATA_WIDTH-1], pos_y}
				: {dir_y[DATA_WIDTH-1], dir_y};
			d_s1[2] <= func ? {dir_z[DATA_WIDTH-1], dir_z} - {pos_z[DATA_WIDTH-1], pos_z}
				: {dir_z[DATA_WIDTH-1], dir_z};
			pos_s1 <= {pos_z, pos_y, pos_x};
			up_s1 <= {up_z, up_y, up_x};
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n1_in[i] = {{(63 - DATA_WIDTH){d_s1[i][DATA_WIDTH]}}, d_s1[i]};
			umag_c[i] = up_s1[i][31] ? -up_s1[i] : up_s1[i];
		end
	end

	lavm_norm u_norm1 (
		.clk  (clk),
		.en   (en),
		.a    (n1_in),
		.o    (n1_o),
		.zero (n1_zero)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			um_s2 <= umag_c;
			un_s2 <= {up_s1[2][31], up_s1[1][31], up_s1[0][31]};
			uor_s2 <= umag_c[0] | umag_c[1] | umag_c[2];
		end
	end

	assign ulen_c = blen({32'd0, uor_s2});

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (ulen_c > 7'd31) begin
				ush_c[i] = um_s2[i] >> (ulen_c - 7'd31);
			end else begin
				ush_c[i] = um_s2[i] << (7'd31 - ulen_c);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				us_s3[i] <= un_s2[i] ? -{1'b0, ush_c[i][30:0]} : {1'b0, ush_c[i][30:0]};
			end
			zu_s3 <= (ulen_c == 7'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			up_dly_q[1] <= '{us: us_s3, zu: zu_s3};
			for (int k = 2; k <= NORM_LAT - 2; k++) begin
				up_dly_q[k] <= up_dly_q[k-1];
			end
			pos1_dly_q[1] <= pos_s1;
			for (int k = 2; k <= NORM_LAT; k++) begin
				pos1_dly_q[k] <= pos1_dly_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cp_s71[0] <= mul_ss($signed(n1_o[1]), $signed(up_dly_q[NORM_LAT-2].us[2]));
			cp_s71[1] <= mul_ss($signed(n1_o[2]), $signed(up_dly_q[NORM_LAT-2].us[1]));
			cp_s71[2] <= mul_ss($signed(n1_o[2]), $signed(up_dly_q[NORM_LAT-2].us[0]));
			cp_s71[3] <= mul_ss($signed(n1_o[0]), $signed(up_dly_q[NORM_LAT-2].us[2]));
			cp_s71[4] <= mul_ss($signed(n1_o[0]), $signed(up_dly_q[NORM_LAT-2].us[1]));
			cp_s71[5] <= mul_ss($signed(n1_o[1]), $signed(up_dly_q[NORM_LAT-2].us[0]));
			w_s71 <= n1_o;
			pos_s71 <= pos1_dly_q[NORM_LAT];
			z_s71 <= n1_zero | up_dly_q[NORM_LAT-2].zu;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				c_s72[i] <= cp_s71[2*i] - cp_s71[2*i+1];
			end
			w_s72 <= w_s71;
			pos_s72 <= pos_s71;
			z_s72 <= z_s71;
		end
	end

	lavm_norm u_norm2 (
		.clk  (clk),
		.en   (en),
		.a    (c_s72),
		.o    (n2_o),
		.zero (n2_zero)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			w2_dly_q[1] <= w_s72;
			pos2_dly_q[1] <= pos_s72;
			for (int k = 2; k <= NORM_LAT; k++) begin
				w2_dly_q[k] <= w2_dly_q[k-1];
				pos2_dly_q[k] <= pos2_dly_q[k-1];
			end
			z2_dly_q <= {z2_dly_q[NORM_LAT-1:1], z_s72};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wu_s142[0] <= mul_ss($signed(w2_dly_q[NORM_LAT][1]), $signed(n2_o[2]));
			wu_s142[1] <= mul_ss($signed(w2_dly_q[NORM_LAT][2]), $signed(n2_o[1]));
			wu_s142[2] <= mul_ss($signed(w2_dly_q[NORM_LAT][2]), $signed(n2_o[0]));
			wu_s142[3] <= mul_ss($signed(w2_dly_q[NORM_LAT][0]), $signed(n2_o[2]));
			wu_s142[4] <= mul_ss($signed(w2_dly_q[NORM_LAT][0]), $signed(n2_o[1]));
			wu_s142[5] <= mul_ss($signed(w2_dly_q[NORM_LAT][1]), $signed(n2_o[0]));
			u_s142 <= n2_o;
			w_s142 <= w2_dly_q[NORM_LAT];
			pos_s142 <= pos2_dly_q[NORM_LAT];
			z_s142 <= z2_dly_q[NORM_LAT] | n2_zero;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 6; k++) begin
				wr_s143[k] <= rnd30(wu_s142[k]);
			end
			u_s143 <= u_s142;
			w_s143 <= w_s142;
			pos_s143 <= pos_s142;
			z_s143 <= z_s142;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				v_s144[i] <= wr_s143[2*i] - wr_s143[2*i+1];
			end
			u_s144 <= u_s143;
			w_s144 <= w_s143;
			pos_s144 <= pos_s143;
			z_s144 <= z_s143;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				tp_s145[i] <= mul_ss($signed(u_s144[i]), $signed(pos_s144[i]));
				tp_s145[3+i] <= mul_ss(v_s144[i], $signed(pos_s144[i]));
				tp_s145[6+i] <= mul_ss($signed(w_s144[i]), $signed(pos_s144[i]));
			end
			u_s145 <= u_s144;
			v_s145 <= v_s144;
			w_s145 <= w_s144;
			z_s145 <= z_s144;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				tr_s146[k] <= rnd30(tp_s145[k]);
			end
			u_s146 <= u_s145;
			v_s146 <= v_s145;
			w_s146 <= w_s145;
			z_s146 <= z_s145;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int b = 0; b < 3; b++) begin
				ts_s147[b] <= -(36'(tr_s146[3*b]) + 36'(tr_s146[3*b+1])
					+ 36'(tr_s146[3*b+2]));
			end
			u_s147 <= u_s146;
			v_s147 <= v_s146;
			w_s147 <= w_s146;
			z_s147 <= z_s146;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				res_s148.u[i] <= z_s147 ? '0 : u_s147[i];
				res_s148.v[i] <= z_s147 ? '0 : v_s147[i][31:0];
				res_s148.w[i] <= z_s147 ? '0 : w_s147[i];
				res_s148.t[i] <= z_s147 ? '0 : sat(ts_s147[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_ready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (vld_s148 && !out_ready) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vld_q) begin
			skid_q <= res_s148;
		end
	end

	assign out_sel = skid_vld_q ? skid_q : res_s148;
	assign out_valid = skid_vld_q || vld_s148;
	assign u_x = out_sel.u[0];
	assign u_y = out_sel.u[1];
	assign u_z = out_sel.u[2];
	assign v_x = out_sel.v[0];
	assign v_y = out_sel.v[1];
	assign v_z = out_sel.v[2];
	assign w_x = out_sel.w[0];
	assign w_y = out_sel.w[1];
	assign w_z = out_sel.w[2];
	assign trans_u = out_sel.t[0];
	assign trans_v = out_sel.t[1];
	assign trans_w = out_sel.t[2];

`ifndef SYNTHESIS
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(!skid_vld_q && vld_s148 && !out_ready) |=> skid_vld_q)
		else $error("stalled result was not captured by the skid register");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |=> ($stable(res_s148) && $stable(vld_s148)))
		else $error("last stage changed while the skid register was full");

	a_w_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s148 |-> ($signed(res_s148.w[0]) <= 32'sh4000_0000
			&& $signed(res_s148.w[0]) >= -32'sh4000_0000
			&& $signed(res_s148.w[1]) <= 32'sh4000_0000
			&& $signed(res_s148.w[1]) >= -32'sh4000_0000
			&& $signed(res_s148.w[2]) <= 32'sh4000_0000
			&& $signed(res_s148.w[2]) >= -32'sh4000_0000))
		else $error("view direction component exceeds unit magnitude");

	a_u_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s148 |-> ($signed(res_s148.u[0]) <= 32'sh4000_0000
			&& $signed(res_s148.u[0]) >= -32'sh4000_0000
			&& $signed(res_s148.u[1]) <= 32'sh4000_0000
			&& $signed(res_s148.u[1]) >= -32'sh4000_0000
			&& $signed(res_s148.u[2]) <= 32'sh4000_0000
			&& $signed(res_s148.u[2]) >= -32'sh4000_0000))
		else $error("side vector component exceeds unit magnitude");
`endif

endmodule

// ===== bench/lavm_checker.sv =====
// Checker for the look-at view matrix core: predicts each camera matrix and compares results.
module lavm_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               func,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	input  logic signed [31:0] up_x,
	input  logic signed [31:0] up_y,
	input  logic signed [31:0] up_z,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] u_x,
	input  logic signed [31:0] u_y,
	input  logic signed [31:0] u_z,
	input  logic signed [31:0] v_x,
	input  logic signed [31:0] v_y,
	input  logic signed [31:0] v_z,
	input  logic signed [31:0] w_x,
	input  logic signed [31:0] w_y,
	input  logic signed [31:0] w_z,
	input  logic signed [31:0] trans_u,
	input  logic signed [31:0] trans_v,
	input  logic signed [31:0] trans_w,
	output int                 errors,
	output int                 pending,
	output int                 matrices_seen,
	output int                 zero_matrices
);
	typedef longint triple_t [3];
	typedef logic [0:11][31:0] view_mat_t;

	localparam string FIELD_NAME [12] = '{"u_x", "u_y", "u_z", "v_x", "v_y", "v_z",
		"w_x", "w_y", "w_z", "trans_u", "trans_v", "trans_w"};

	view_mat_t expected_mats [$];

	function automatic bit scale_pow2(input triple_t a, input int top, output triple_t o);
		longint unsigned m [3];
		longint unsigned mx;
		bit ng [3];
		int len;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			ng[i] = a[i] < 0;
			m[i] = ng[i] ? longint'(-a[i]) : longint'(a[i]);
			if (m[i] > mx) begin
				mx = m[i];
			end
		end
		if (mx == 0) begin
			return 0;
		end
		len = 0;
		while (len < 63 && (mx >> len) != 0) begin
			len++;
		end
		for (int i = 0; i < 3; i++) begin
			if (len - 1 > top) begin
				m[i] = m[i] >> (len - 1 - top);
			end else begin
				m[i] = m[i] << (top - (len - 1));
			end
			o[i] = ng[i] ? -longint'(m[i]) : longint'(m[i]);
		end
		return 1;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) begin
			b = b >> 2;
		end
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic bit unit_vec(input triple_t a, output triple_t o);
		triple_t sc;
		longint unsigned m [3];
		longint unsigned sum, s;
		if (!scale_pow2(a, 29, sc)) begin
			return 0;
		end
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = sc[i] < 0 ? longint'(-sc[i]) : longint'(sc[i]);
			sum = sum + m[i] * m[i];
		end
		s = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			o[i] = longint'(((m[i] << 30) + (s >> 1)) / s);
			if (sc[i] < 0) begin
				o[i] = -o[i];
			end
		end
		return 1;
	endfunction

	function automatic longint mul_q30(input longint b, input longint p);
		logic [127:0] mb, mp, prod;
		mb = b < 0 ? 128'(-b) : 128'(b);
		mp = p < 0 ? 128'(-p) : 128'(p);
		prod = (mb * mp + (128'd1 << 29)) >> 30;
		return ((b < 0) != (p < 0)) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
	endfunction

	function automatic logic [31:0] neg_dot_sat(input triple_t b, input triple_t p);
		longint t;
		t = -(mul_q30(b[0], p[0]) + mul_q30(b[1], p[1]) + mul_q30(b[2], p[2]));
		if (t > 64'sd2147483647) begin
			t = 64'sd2147483647;
		end
		if (t < -64'sd2147483648) begin
			t = -64'sd2147483648;
		end
		return t[31:0];
	endfunction

	function automatic view_mat_t predict_view(input logic target_mode, input triple_t p,
			input triple_t d_in, input triple_t up);
		triple_t d, w, us, c, u, v;
		view_mat_t r;
		r = '0;
		for (int i = 0; i < 3; i++) begin
			d[i] = target_mode ? d_in[i] - p[i] : d_in[i];
		end
		if (unit_vec(d, w) && scale_pow2(up, 30, us)) begin
			c[0] = w[1] * us[2] - w[2] * us[1];
			c[1] = w[2] * us[0] - w[0] * us[2];
			c[2] = w[0] * us[1] - w[1] * us[0];
			if (unit_vec(c, u)) begin
				v[0] = mul_q30(w[1], u[2]) - mul_q30(w[2], u[1]);
				v[1] = mul_q30(w[2], u[0]) - mul_q30(w[0], u[2]);
				v[2] = mul_q30(w[0], u[1]) - mul_q30(w[1], u[0]);
				for (int i = 0; i < 3; i++) begin
					r[i] = u[i][31:0];
					r[3 + i] = v[i][31:0];
					r[6 + i] = w[i][31:0];
				end
				r[9] = neg_dot_sat(u, p);
				r[10] = neg_dot_sat(v, p);
				r[11] = neg_dot_sat(w, p);
			end
		end
		return r;
	endfunction

	assign pending = expected_mats.size();

	always @(posedge clk or negedge arst_n) begin
		triple_t p, d, up;
		view_mat_t got, want;
		if (!arst_n) begin
			errors <= 0;
			matrices_seen <= 0;
			zero_matrices <= 0;
		end else begin
			if (in_valid && in_ready) begin
				p = '{longint'(pos_x), longint'(pos_y), longint'(pos_z)};
				d = '{longint'(dir_x), longint'(dir_y), longint'(dir_z)};
				up = '{longint'(up_x), longint'(up_y), longint'(up_z)};
				expected_mats.push_back(predict_view(func, p, d, up));
			end
			if (out_valid && out_ready) begin
				got = {u_x, u_y, u_z, v_x, v_y, v_z, w_x, w_y, w_z,
					trans_u, trans_v, trans_w};
				matrices_seen <= matrices_seen + 1;
				if (expected_mats.size() == 0) begin
					$error("Result transaction arrived with no matrix expected");
					errors <= errors + 1;
				end else begin
					want = expected_mats.pop_front();
					if (want == '0) begin
						zero_matrices <= zero_matrices + 1;
					end
					if (got !== want) begin
						errors <= errors + 1;
					end
					for (int i = 0; i < 12; i++) begin
						if (got[i] !== want[i]) begin
							$error("%s mismatch: expected %h, got %h",
								FIELD_NAME[i], want[i], got[i]);
						end
					end
				end
			end
		end
	end
endmodule

// ===== bench/tb.sv =====
// Testbench top for the look-at view matrix core: stimulus, idling and the final verdict.
module tb;
	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic func = 0;
	logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
	logic signed [31:0] dir_x = 0, dir_y = 0, dir_z = 0;
	logic signed [31:0] up_x = 0, up_y = 0, up_z = 0;
	logic signed [31:0] u_x, u_y, u_z, v_x, v_y, v_z, w_x, w_y, w_z;
	logic signed [31:0] trans_u, trans_v, trans_w;
	int errors, pending, matrices_seen, zero_matrices;
	int sent = 0;
	bit stim_done = 0;

	localparam logic signed [31:0] MAXV = 32'sh7fffffff;
	localparam logic signed [31:0] MINV = 32'sh80000000;
	localparam logic signed [31:0] ONE = 32'sh00010000;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	look_at_view_matrix_core dut (.*);

	lavm_checker chk (.*);

	task automatic send_camera(input logic f, input logic signed [31:0] px, py, pz,
			dx, dy, dz, ux, uy, uz, input int gap);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		func <= f;
		pos_x <= px; pos_y <= py; pos_z <= pz;
		dir_x <= dx; dir_y <= dy; dir_z <= dz;
		up_x <= ux; up_y <= uy; up_z <= uz;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] rand_coord();
		logic signed [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 4))
			0: return r;
			1: return r >>> $urandom_range(0, 31);
			2: return $signed($urandom_range(0, 400)) - 200;
			3: return $urandom_range(0, 1) ? MAXV : MINV;
			default: return r >>> $urandom_range(8, 20);
		endcase
	endfunction

	initial begin
		logic signed [31:0] c [9];
		int gap;
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send_camera(0, 0, 0, 0, 0, 0, -ONE, 0, ONE, 0, 0);
		send_camera(1, ONE, 2 * ONE, 3 * ONE, 0, 0, 0, 0, ONE, 0, 0);
		send_camera(0, 0, 0, 0, 0, 0, 0, 0, ONE, 0, 0);
		send_camera(0, ONE, ONE, ONE, ONE, 0, 0, 0, 0, 0, 1);
		send_camera(0, 0, 0, 0, 0, ONE, 0, 0, 3 * ONE, 0, 0);
		send_camera(1, 5, 5, 5, 5, 5, 5, 0, ONE, 0, 2);
		send_camera(1, MINV, MINV, MINV, MAXV, MAXV, MAXV, 0, 0, ONE, 0);
		send_camera(1, MAXV, 0, MINV, MINV, 1, MAXV, ONE, 0, 0, 0);
		send_camera(0, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MINV, MAXV, 0, 3);
		send_camera(0, MINV, MINV, MINV, MINV, MINV, MINV, MAXV, MINV, 1, 0);
		send_camera(0, MAXV, MINV, MAXV, 1, 0, 0, 0, 1, 0, 0);
		send_camera(0, MINV, MAXV, MINV, 0, 0, -1, 0, -1, 1, 0);
		send_camera(0, -1, -1, -1, -1, -1, -1, -1, 1, -1, 1);
		send_camera(1, 32'sh40000000, 0, 0, MINV, 0, 0, 0, 0, MAXV, 0);
		send_camera(0, 3 * ONE, -7 * ONE, ONE, ONE, -ONE, ONE, 0, ONE, 0, 0);
		send_camera(0, 0, 0, 0, ONE, 2 * ONE, 3 * ONE, 2 * ONE, 4 * ONE, 6 * ONE, 0);
		for (int n = 0; n < 2000; n++) begin
			for (int k = 0; k < 9; k++) c[k] = rand_coord();
			if ((n % 500) < 100) gap = 0;
			else gap = $urandom_range(0, 3);
			send_camera($urandom_range(0, 1), c[0], c[1], c[2], c[3], c[4], c[5],
				c[6], c[7], c[8], gap);
		end
		in_valid <= 0;
		stim_done = 1;
	end

	initial begin
		int stall;
		int taken = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (taken == 200) begin
				out_ready <= 0;
				repeat (400) @(negedge clk);
			end
			if (((taken + 1) % 500) < 100) stall = 0;
			else stall = $urandom_range(0, 3);
			if (stall != 0) begin
				out_ready <= 0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
		end
	end

	initial begin
		wait (stim_done);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("Sent %0d camera setups, checked %0d matrices (%0d degenerate, all zero).",
			sent, matrices_seen, zero_matrices);
		$display("Covered both modes, extreme and tiny vectors, and a long output stall.");
		if (errors == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end
endmodule
